[design/ba_pkg.sv]
package ba_pkg;

	localparam int unsigned MaxOrder = 8;
	localparam int unsigned NumOrders = MaxOrder + 1;
	localparam int unsigned NumEntries = (1 << (MaxOrder + 1)) - 1;
	localparam int unsigned AddrW = $clog2(NumEntries);
	localparam int unsigned OffW = 8;
	localparam int unsigned OrdW = 4;
	localparam int unsigned CntW = MaxOrder + 1;
	localparam int unsigned ResetPool = (8 > MaxOrder) ? MaxOrder : 8;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	typedef logic [CntW-1:0] cnt_t;
	typedef logic [OrdW-1:0] ord_t;
	typedef logic [OffW-1:0] off_t;
	typedef logic [AddrW-1:0] addr_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		off_t  wdata;
		addr_t raddr;
	} mem_req_t;

	function automatic addr_t stack_base(input ord_t o);
		logic [AddrW:0] full;
		full = (AddrW + 1)'(1 << (MaxOrder + 1)) - ((AddrW + 1)'(1) << (MaxOrder + 1 - o));
		return full[AddrW-1:0];
	endfunction

	function automatic cnt_t stack_cap(input ord_t o);
		return cnt_t'(1) << (MaxOrder - o);
	endfunction

endpackage

[design/ba_ram.sv]
module ba_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 511
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/ba_seq.sv]
module ba_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [3:0]            cfg_data,
	input  logic                  start,
	input  logic                  cmd,
	input  logic [15:0]           request_size,
	input  ba_pkg::off_t          block_offset,
	input  ba_pkg::ord_t          block_order,
	input  logic                  res_ready,
	output logic                  busy,
	output logic                  done,
	output logic                  res_ok,
	output ba_pkg::off_t          res_off,
	output ba_pkg::mem_req_t      mreq,
	input  ba_pkg::off_t          rdata
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_FIND  = 11'b00000000010,
		S_CHK   = 11'b00000000100,
		S_POPRD = 11'b00000001000,
		S_SPLIT = 11'b00000010000,
		S_GRANT = 11'b00000100000,
		S_SRCH  = 11'b00001000000,
		S_SWAP  = 11'b00010000000,
		S_PUSH  = 11'b00100000000,
		S_DONE  = 11'b01000000000,
		S_INIT  = 11'b10000000000
	} state_t;

	state_t state_q;
	ba_pkg::cnt_t cnt_q [ba_pkg::NumOrders];
	ba_pkg::ord_t pool_q, target_q, ord_q;
	ba_pkg::off_t cur_q, buddy_q, off_q;
	ba_pkg::cnt_t idx_q;
	logic trial_q, rd_pend_q, ok_q, hi_q;

	ba_pkg::ord_t tgt_c;
	ba_pkg::off_t mask_c;
	logic [15:0] sz_c;
	ba_pkg::cnt_t cnt_c;
	ba_pkg::ord_t cfg_pool_c;

	always_comb begin
		sz_c = (request_size == 16'd0) ? 16'd0 : request_size - 16'd1;
		tgt_c = '0;
		for (int i = 0; i < 16; i++) begin
			if (sz_c[i]) begin
				tgt_c = ba_pkg::ord_t'(i + 1);
			end
		end
		mask_c = ba_pkg::off_t'((9'd1 << pool_q) - 9'd1) & ~ba_pkg::off_t'((9'd1 << block_order) - 9'd1);
		cnt_c = cnt_q[ord_q[3:0]];
		cfg_pool_c = (cfg_data > 4'(ba_pkg::MaxOrder)) ? ba_pkg::ord_t'(ba_pkg::MaxOrder) : cfg_data;
	end

	always_comb begin
		mreq = '0;
		case (state_q)
			S_POPRD: mreq.raddr = ba_pkg::stack_base(ord_q) + ba_pkg::addr_t'(cnt_c - 1'b1);
			S_SRCH:  mreq.raddr = ba_pkg::stack_base(ord_q) + ba_pkg::addr_t'(idx_q);
			S_SWAP:  mreq.raddr = ba_pkg::stack_base(ord_q) + ba_pkg::addr_t'(cnt_c - 1'b1);
			S_SPLIT: begin
				mreq.we = 1'b1;
				mreq.waddr = ba_pkg::stack_base(ord_q) + ba_pkg::addr_t'(cnt_c) + ba_pkg::addr_t'(hi_q);
				mreq.wdata = hi_q ? off_q : rdata + ba_pkg::off_t'(9'd1 << ord_q);
			end
			S_PUSH: begin
				mreq.we = rd_pend_q;
				mreq.waddr = ba_pkg::stack_base(ord_q) + ba_pkg::addr_t'(idx_q);
				mreq.wdata = rdata;
			end
			S_DONE: begin
				mreq.we = ok_q && (cmd == ba_pkg::CMD_FREE);
				mreq.waddr = ba_pkg::stack_base(ord_q) + ba_pkg::addr_t'(cnt_c);
				mreq.wdata = cur_q;
			end
			S_INIT: begin
				mreq.we = 1'b1;
				mreq.waddr = ba_pkg::stack_base(ord_q);
				mreq.wdata = '0;
			end
			default: mreq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			pool_q <= ba_pkg::ord_t'(ba_pkg::ResetPool);
			for (int i = 0; i < ba_pkg::NumOrders; i++) begin
				cnt_q[i] <= (i == ba_pkg::ResetPool) ? ba_pkg::cnt_t'(1) : '0;
			end
			ok_q <= 1'b0;
			trial_q <= 1'b0;
			rd_pend_q <= 1'b0;
			hi_q <= 1'b0;
			ord_q <= ba_pkg::ord_t'(ba_pkg::ResetPool);
			target_q <= '0;
			idx_q <= '0;
			cur_q <= '0;
			buddy_q <= '0;
			off_q <= '0;
		end else if (cfg_we) begin
			pool_q <= cfg_pool_c;
			for (int i = 0; i < ba_pkg::NumOrders; i++) begin
				cnt_q[i] <= (ba_pkg::ord_t'(i) == cfg_pool_c) ? ba_pkg::cnt_t'(1) : '0;
			end
			state_q <= S_INIT;
			rd_pend_q <= 1'b0;
			idx_q <= '0;
			ord_q <= cfg_pool_c;
			cur_q <= '0;
			ok_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ok_q <= 1'b0;
						if (cmd == ba_pkg::CMD_ALLOC) begin
							cur_q <= '0;
							target_q <= tgt_c;
							ord_q <= tgt_c;
							state_q <= (request_size > (16'd1 << pool_q)) ? S_DONE : S_FIND;
						end else begin
							ord_q <= block_order;
							cur_q <= block_offset & mask_c;
							off_q <= block_offset & mask_c;
							trial_q <= 1'b1;
							idx_q <= '0;
							state_q <= (block_order > pool_q) ? S_DONE : S_SRCH;
						end
					end
				end
				S_FIND: begin
					if (ord_q > pool_q) begin
						state_q <= S_DONE;
					end else if (cnt_c != '0) begin
						off_q <= '0;
						buddy_q <= ba_pkg::off_t'(ord_q);
						ord_q <= target_q;
						state_q <= S_CHK;
					end else begin
						ord_q <= ord_q + 1'b1;
					end
				end
				S_CHK: begin
					if (ord_q == ba_pkg::ord_t'(buddy_q)) begin
						state_q <= S_POPRD;
					end else if ({1'b0, cnt_c} + 10'd2 > {1'b0, ba_pkg::stack_cap(ord_q)}) begin
						state_q <= S_DONE;
					end else begin
						ord_q <= ord_q + 1'b1;
					end
				end
				S_POPRD: begin
					cnt_q[ord_q] <= cnt_c - 1'b1;
					hi_q <= 1'b0;
					state_q <= (ord_q == target_q) ? S_GRANT : S_SPLIT;
					if (ord_q != target_q) begin
						ord_q <= ord_q - 1'b1;
					end
				end
				S_SPLIT: begin
					if (!hi_q) begin
						off_q <= rdata;
						hi_q <= 1'b1;
					end else begin
						cnt_q[ord_q] <= cnt_c + 2'd2;
						state_q <= S_POPRD;
					end
				end
				S_GRANT: begin
					ok_q <= 1'b1;
					cur_q <= rdata;
					state_q <= S_DONE;
				end
				S_SRCH: begin
					if (rd_pend_q && rdata == buddy_q) begin
						rd_pend_q <= 1'b0;
						if (trial_q) begin
							cur_q <= (cur_q < buddy_q) ? cur_q : buddy_q;
							ord_q <= ord_q + 1'b1;
							idx_q <= '0;
						end else begin
							idx_q <= idx_q - 1'b1;
							state_q <= S_SWAP;
						end
					end else if (!rd_pend_q && (ord_q >= pool_q || idx_q >= cnt_c)) begin
						if (trial_q) begin
							if (cnt_c >= ba_pkg::stack_cap(ord_q)) begin
								state_q <= S_DONE;
							end else begin
								trial_q <= 1'b0;
								ord_q <= block_order;
								cur_q <= off_q;
								idx_q <= '0;
							end
						end else begin
							ok_q <= 1'b1;
							state_q <= S_DONE;
						end
					end else if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else begin
						buddy_q <= cur_q ^ ba_pkg::off_t'(9'd1 << ord_q);
						rd_pend_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SWAP: begin
					cnt_q[ord_q] <= cnt_c - 1'b1;
					rd_pend_q <= 1'b1;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (rd_pend_q) begin
						cur_q <= (cur_q < buddy_q) ? cur_q : buddy_q;
						ord_q <= ord_q + 1'b1;
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						state_q <= S_SRCH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						if (ok_q && cmd == ba_pkg::CMD_FREE) begin
							cnt_q[ord_q] <= cnt_c + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_INIT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE) && res_ready;
	assign res_ok = ok_q;
	assign res_off = (ok_q && cmd == ba_pkg::CMD_ALLOC) ? cur_q : '0;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_ready) |=> state_q == S_IDLE)
		else $error("done not followed by idle");
	a_pool: assert property (@(posedge clk) disable iff (!arst_n)
		pool_q <= ba_pkg::ord_t'(ba_pkg::MaxOrder))
		else $error("pool order out of range");

endmodule

[design/buddy_allocator_top.sv]
// This block hands out and takes back power-of-two blocks of a pool of units.
// An item on the input channel (in_valid, in_ready) either allocates a block of
// request_size units or frees the block given by block_offset and block_order.
// Each item gives exactly one result item on the output channel (out_valid,
// out_ready): ok and, for a successful allocation, granted_offset.
// The block works on one item at a time; in_ready is low meanwhile and while
// cfg_valid is high. A successful allocation takes longer for each split; one
// rejected for its size goes straight to its result. A free takes longer for
// each stack entry compared during the buddy searches, which run twice (a trial
// pass and a commit pass), and for each merge, since the search alternates
// address and data on the single read port of the stack memory.
// The next item can be accepted in the cycle in which out_valid rises.
// A result waits in an output register while out_ready is low; the next item
// is accepted meanwhile, and its result is held back until the register is free.
// A write on the configuration channel (cfg_valid, cfg_ready) sets pool_order,
// saturating at the largest order, and leaves the whole pool as one free block.
// Reset makes the pool order 8 and the whole pool one free block; reset and a
// configuration write each go through an init state to set up the stack memory.
module buddy_allocator_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         cmd,
	input  logic [15:0]  request_size,
	input  logic [7:0]   block_offset,
	input  logic [3:0]   block_order,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         ok,
	output logic [7:0]   granted_offset
);

	logic busy, done, res_ok, cfg_we;
	ba_pkg::off_t res_off, rdata;
	ba_pkg::mem_req_t mreq;
	logic cmd_q;
	logic [15:0] size_q;
	ba_pkg::off_t boff_q;
	ba_pkg::ord_t bord_q;
	logic start;
	logic res_ready;

	assign in_ready = !busy && !cfg_valid;
	assign cfg_ready = !busy;
	assign cfg_we = cfg_valid && cfg_ready;
	assign start = in_valid && in_ready && !cfg_we;
	assign res_ready = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= cmd;
			size_q <= request_size;
			boff_q <= block_offset;
			bord_q <= block_order;
		end
	end

	ba_seq u_seq (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.start(start),
		.cmd(start ? cmd : cmd_q),
		.request_size(start ? request_size : size_q),
		.block_offset(start ? block_offset : boff_q),
		.block_order(start ? block_order : bord_q),
		.res_ready(res_ready),
		.busy(busy), .done(done), .res_ok(res_ok), .res_off(res_off),
		.mreq(mreq), .rdata(rdata)
	);

	ba_ram #(.Width(ba_pkg::OffW), .Depth(ba_pkg::NumEntries)) u_ram (
		.clk(clk), .we(mreq.we), .waddr(mreq.waddr), .wdata(mreq.wdata),
		.raddr(mreq.raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (done) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			ok <= res_ok;
			granted_offset <= res_off;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !done)
		else $error("result overwritten while stalled");

endmodule

[bench/buddy_allocator_checker.sv]
module buddy_allocator_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] request_size,
	input  logic [7:0]  block_offset,
	input  logic [3:0]  block_order,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        ok,
	input  logic [7:0]  granted_offset,
	output int          fails,
	output int          pending
);

	typedef struct {
		logic       ok;
		logic [7:0] offset;
	} grant_t;

	grant_t      grants_due[$];
	logic [7:0]  free_ent [0:ba_pkg::NumEntries-1];
	int unsigned free_cnt [0:ba_pkg::MaxOrder];
	int unsigned pool_ord;

	function automatic int unsigned order_base(int unsigned o);
		return (1 << (ba_pkg::MaxOrder + 1)) - ((1 << (ba_pkg::MaxOrder + 1)) >> o);
	endfunction

	function automatic int unsigned order_cap(int unsigned o);
		return (1 << ba_pkg::MaxOrder) >> o;
	endfunction

	function automatic void push_free(int unsigned o, logic [7:0] v);
		free_ent[order_base(o) + free_cnt[o]] = v;
		free_cnt[o]++;
	endfunction

	function automatic logic [7:0] pop_free(int unsigned o);
		free_cnt[o]--;
		return free_ent[order_base(o) + free_cnt[o]];
	endfunction

	function automatic int find_free(int unsigned o, int unsigned v);
		for (int unsigned i = 0; i < free_cnt[o]; i++)
			if (free_ent[order_base(o) + i] == v[7:0])
				return int'(i);
		return -1;
	endfunction

	function automatic void empty_pool();
		for (int i = 0; i < ba_pkg::NumEntries; i++)
			free_ent[i] = '0;
		for (int i = 0; i <= ba_pkg::MaxOrder; i++)
			free_cnt[i] = 0;
		push_free(pool_ord, 8'd0);
	endfunction

	function automatic grant_t allocate(int unsigned size);
		int unsigned target;
		int unsigned found;
		logic [7:0]  base_off;
		grant_t      g;
		g.ok = 1'b0;
		g.offset = '0;
		target = 0;
		if (size == 0)
			size = 1;
		while (target < 31 && (1 << target) < size)
			target++;
		if (target > pool_ord)
			return g;
		found = target;
		while (found <= pool_ord && free_cnt[found] == 0)
			found++;
		if (found > pool_ord)
			return g;
		for (int unsigned k = target; k < found; k++)
			if (free_cnt[k] + 2 > order_cap(k))
				return g;
		while (found > target) begin
			base_off = pop_free(found);
			found--;
			push_free(found, base_off + 8'(1 << found));
			push_free(found, base_off);
		end
		g.ok = 1'b1;
		g.offset = pop_free(target);
		return g;
	endfunction

	function automatic logic release_block(int unsigned off, int unsigned ord);
		int unsigned o;
		int unsigned cur;
		int unsigned buddy;
		int          pos;
		logic [7:0]  top;
		if (ord > pool_ord)
			return 1'b0;
		off &= (1 << pool_ord) - 1;
		off &= ~((1 << ord) - 1);
		o = ord;
		cur = off;
		while (o < pool_ord) begin
			buddy = cur ^ (1 << o);
			if (find_free(o, buddy) < 0)
				break;
			cur = cur < buddy ? cur : buddy;
			o++;
		end
		if (free_cnt[o] >= order_cap(o))
			return 1'b0;
		o = ord;
		cur = off;
		while (o < pool_ord) begin
			buddy = cur ^ (1 << o);
			pos = find_free(o, buddy);
			if (pos < 0)
				break;
			top = pop_free(o);
			if (pos < free_cnt[o])
				free_ent[order_base(o) + pos] = top;
			cur = cur < buddy ? cur : buddy;
			o++;
		end
		push_free(o, cur[7:0]);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t g;
		grant_t want;
		if (!arst_n) begin
			pool_ord = ba_pkg::ResetPool;
			empty_pool();
			grants_due.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pool_ord = cfg_data > ba_pkg::MaxOrder ? ba_pkg::MaxOrder : cfg_data;
				empty_pool();
			end
			if (in_valid && in_ready) begin
				if (cmd == ba_pkg::CMD_ALLOC) begin
					g = allocate(request_size);
				end else begin
					g.ok = release_block(block_offset, block_order);
					g.offset = '0;
				end
				grants_due = {grants_due, g};
			end
			if (out_valid && out_ready) begin
				if (grants_due.size() == 0) begin
					$error("Result item with no item outstanding: ok=%0d offset=%0d",
						ok, granted_offset);
					fails++;
				end else begin
					want = grants_due.pop_front();
					if (ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, ok);
						fails++;
					end
					if (granted_offset !== want.offset) begin
						$error("granted_offset: expected %0d, got %0d",
							want.offset, granted_offset);
						fails++;
					end
				end
			end
			pending = grants_due.size();
		end
	end
endmodule

[bench/tb_buddy_allocator_top.sv]
module tb_buddy_allocator_top;

	localparam int StallLimit = 50000;

	typedef struct {
		logic [7:0] off;
		int         ord;
	} block_t;

	typedef struct {
		logic cmd;
		int   ord;
	} sent_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [15:0] request_size;
	logic [7:0]  block_offset;
	logic [3:0]  block_order;
	logic        out_valid;
	logic        out_ready;
	logic        ok;
	logic [7:0]  granted_offset;
	int          fails;
	int          pending;
	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          rx_hold_go;
	int          quiet_cycles;
	int          cur_pool;
	block_t      live_q[$];
	sent_t       sent_q[$];

	buddy_allocator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.request_size(request_size), .block_offset(block_offset),
		.block_order(block_order),
		.out_valid(out_valid), .out_ready(out_ready), .ok(ok),
		.granted_offset(granted_offset)
	);

	buddy_allocator_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.request_size(request_size), .block_offset(block_offset),
		.block_order(block_order),
		.out_valid(out_valid), .out_ready(out_ready), .ok(ok),
		.granted_offset(granted_offset),
		.fails(fails), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int size_order(int unsigned size);
		int o;
		o = 0;
		while ((1 << o) < size)
			o++;
		return o;
	endfunction

	// Successful grants are kept so that most frees return a block really in use.
	always @(posedge clk) begin
		sent_t  s;
		block_t b;
		if (arst_n && out_valid && out_ready && sent_q.size() > 0) begin
			s = sent_q.pop_front();
			if (s.cmd == ba_pkg::CMD_ALLOC && ok) begin
				b.off = granted_offset;
				b.ord = s.ord;
				live_q = {live_q, b};
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("buddy_allocator_top regression: fail");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_go) begin
				rx_hold_go = 1'b0;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic send(logic c, logic [15:0] size, logic [7:0] off, logic [3:0] ord);
		sent_t s;
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		request_size <= size;
		block_offset <= off;
		block_order <= ord;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		s.cmd = c;
		s.ord = size_order(size);
		sent_q = {sent_q, s};
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_pool(logic [3:0] v);
		drain();
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_pool = v > ba_pkg::MaxOrder ? int'(ba_pkg::MaxOrder) : int'(v);
		live_q.delete();
	endtask

	task automatic random_item();
		int     pick;
		int     r;
		int     i;
		block_t b;
		logic [15:0] size;
		pick = int'($urandom_range(99));
		if (pick < 45 || (pick < 85 && live_q.size() == 0)) begin
			if ($urandom_range(3) != 0)
				r = int'($urandom_range(cur_pool < 3 ? cur_pool : 3));
			else
				r = int'($urandom_range(cur_pool));
			if (r == 0)
				size = 16'($urandom_range(1));
			else
				size = 16'($urandom_range(1 << r, (1 << (r - 1)) + 1));
			send(ba_pkg::CMD_ALLOC, size, 8'($urandom), 4'($urandom));
		end else if (pick < 85) begin
			i = int'($urandom_range(live_q.size() - 1));
			b = live_q[i];
			live_q.delete(i);
			send(ba_pkg::CMD_FREE, 16'($urandom), b.off, 4'(b.ord));
		end else if (pick < 92) begin
			send(1'($urandom), 16'($urandom), 8'($urandom), 4'($urandom));
		end else begin
			r = int'($urandom_range(cur_pool));
			send(ba_pkg::CMD_FREE, 16'($urandom),
				8'($urandom_range(255) & ~((1 << r) - 1)), 4'(r));
		end
	endtask

	initial begin
		logic [3:0] pools [8];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = ba_pkg::CMD_ALLOC;
		request_size = '0;
		block_offset = '0;
		block_order = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_go = 1'b0;
		cur_pool = ba_pkg::ResetPool;
		pools = '{4'd3, 4'd0, 4'd15, 4'd6, 4'd8, 4'd1, 4'd5, 4'd8};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(ba_pkg::CMD_ALLOC, 16'hFFFF, 8'h00, 4'h0);
		send(ba_pkg::CMD_ALLOC, 16'd0, 8'h00, 4'h0);
		send(ba_pkg::CMD_ALLOC, 16'd1, 8'h00, 4'h0);
		send(ba_pkg::CMD_ALLOC, 16'd3, 8'h00, 4'h0);
		send(ba_pkg::CMD_ALLOC, 16'd256, 8'h00, 4'h0);
		send(ba_pkg::CMD_ALLOC, 16'd128, 8'h00, 4'h0);
		send(ba_pkg::CMD_ALLOC, 16'd100, 8'h00, 4'h0);
		send(ba_pkg::CMD_FREE, 16'h0000, 8'h00, 4'hF);
		send(ba_pkg::CMD_FREE, 16'hFFFF, 8'hFF, 4'h0);
		send(ba_pkg::CMD_FREE, 16'h0000, 8'h01, 4'h0);
		send(ba_pkg::CMD_FREE, 16'h0000, 8'h01, 4'h0);
		send(ba_pkg::CMD_FREE, 16'h0000, 8'h04, 4'h2);
		send(ba_pkg::CMD_FREE, 16'h0000, 8'h80, 4'h7);
		send(ba_pkg::CMD_FREE, 16'h0000, 8'h00, 4'h8);
		send(ba_pkg::CMD_FREE, 16'h0000, 8'h00, 4'h8);
		send(ba_pkg::CMD_ALLOC, 16'd257, 8'h00, 4'h0);
		send(ba_pkg::CMD_ALLOC, 16'd256, 8'h00, 4'h0);
		send(ba_pkg::CMD_ALLOC, 16'd1, 8'h00, 4'h0);
		send(ba_pkg::CMD_FREE, 16'h0000, 8'h00, 4'h8);
		for (int k = 0; k < 8; k++)
			send(ba_pkg::CMD_FREE, 16'h0000, 8'(k * 32), 4'h5);
		send(ba_pkg::CMD_FREE, 16'h0000, 8'h00, 4'h0);

		for (int seg = 0; seg < 8; seg++) begin
			set_pool(pools[seg]);
			if (seg < 3) begin
				tx_idle_pct = 20;
				rx_idle_pct = 45;
			end else if (seg < 6) begin
				tx_idle_pct = 45;
				rx_idle_pct = 20;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			for (int n = 0; n < 125; n++) begin
				if (n == 30 && (seg == 1 || seg == 6))
					rx_hold_go = 1'b1;
				if (n == 60)
					drain();
				random_item();
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("buddy_allocator_top regression: pass");
		else
			$display("buddy_allocator_top regression: fail");
		$finish;
	end
endmodule
